[sv/blh_pkg.sv]
// Shared types, constants and helpers for the bucketed latency histogram.
`default_nettype none
package blh_pkg;
    localparam int NUM_BUCKETS = 8;
    localparam int NUM_BOUNDS  = NUM_BUCKETS - 1;
    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 48;
    localparam int SUM_BITS    = 64;
    localparam int FRAC_BITS   = 17;
    localparam int IDX_BITS    = 3;
    localparam int PROD_BITS   = COUNT_BITS + SAMPLE_BITS;
    localparam int DIV_STEPS   = PROD_BITS;
    localparam int DCNT_BITS   = $clog2(DIV_STEPS + 1);
    localparam int HALF_BITS   = COUNT_BITS / 2;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    localparam logic [2:0] REG_BOUNDS_IN_USE = 3'd0;

    localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(65536);

    typedef logic [SAMPLE_BITS-1:0] bound_arr_t [NUM_BOUNDS];

    typedef struct packed {
        logic [1:0]             func;
        logic [SAMPLE_BITS-1:0] sample;
        logic [FRAC_BITS-1:0]   fraction;
        logic [IDX_BITS-1:0]    bucket_sel;
        logic [IDX_BITS-1:0]    bucket;
    } blh_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TGT, ST_WALK, ST_MUL_LO, ST_MUL_HI, ST_MUL_FR, ST_SUM, ST_DIV, ST_DONE
    } blh_state_t;

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

[sv/blh_front.sv]
// Front end: input queue that classifies record samples into buckets on entry.
`default_nettype none
module blh_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     func,
    input  wire logic [blh_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic [blh_pkg::FRAC_BITS-1:0]  fraction,
    input  wire logic [blh_pkg::IDX_BITS-1:0]   bucket_sel,
    input  wire blh_pkg::bound_arr_t            bounds,
    input  wire logic [blh_pkg::IDX_BITS-1:0]   used,
    output logic                                head_valid,
    output blh_pkg::blh_item_t                  head,
    input  wire logic                           head_take
);
    import blh_pkg::*;

    blh_item_t  q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [IDX_BITS-1:0] bucket;
    logic       do_push, do_pop;

    // first bound at or above the sample, else the unbounded bucket
    always_comb
    begin
        bucket = used;
        for (int i = NUM_BOUNDS - 1; i >= 0; i--)
        begin
            if ((IDX_BITS'(i) < used) && (sample <= bounds[i]))
                bucket = IDX_BITS'(i);
        end
    end

    assign full       = cnt_reg[1];
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= '{func: func, sample: sample, fraction: fraction,
                                   bucket_sel: bucket_sel, bucket: bucket};
    end
endmodule
`default_nettype wire

[sv/blh_back.sv]
// Back end: statistics, cumulative walk, interpolation and divider, result register.
`default_nettype none
module blh_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            head_valid,
    input  wire blh_pkg::blh_item_t              head,
    output logic                                 head_take,
    input  wire blh_pkg::bound_arr_t             bounds,
    input  wire logic [blh_pkg::IDX_BITS-1:0]    used,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [2:0]                           hit_bucket,
    output logic [blh_pkg::COUNT_BITS-1:0]       total_count,
    output logic [blh_pkg::SUM_BITS-1:0]         sum_total,
    output logic [blh_pkg::SAMPLE_BITS-1:0]      min_sample,
    output logic [blh_pkg::SAMPLE_BITS-1:0]      max_sample,
    output logic [blh_pkg::COUNT_BITS-1:0]       answer,
    output logic                                 is_empty
);
    import blh_pkg::*;

    blh_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]  cnt_reg [NUM_BUCKETS];
    logic [COUNT_BITS-1:0]  count_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0] min_reg, max_reg;

    logic [1:0]             func_reg;
    logic [IDX_BITS-1:0]    hit_reg, sel_reg, idx_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [COUNT_BITS-1:0]  acc_reg, tint_reg, a_reg, d_reg, ans_reg;
    logic [15:0]            tfrac_reg;
    logic [SAMPLE_BITS-1:0] lb_reg, w_reg;
    logic [PROD_BITS-1:0]   x_reg, m_reg;
    logic [COUNT_BITS:0]    rem_reg;
    logic [DCNT_BITS-1:0]   dcnt_reg;

    logic                   out_valid_reg;
    logic [2:0]             o_hit_reg;
    logic [COUNT_BITS-1:0]  o_count_reg, o_ans_reg;
    logic [SUM_BITS-1:0]    o_sum_reg;
    logic [SAMPLE_BITS-1:0] o_min_reg, o_max_reg;
    logic                   o_empty_reg;

    logic [IDX_BITS-1:0]    rd_idx, sel_c;
    logic [COUNT_BITS-1:0]  cnt_rd, nacc;
    logic [SAMPLE_BITS-1:0] ub;
    logic                   found, is_last, load_out;
    logic [SUM_BITS:0]      sum_ext;
    logic [63:0]            tgt;
    logic [COUNT_BITS:0]    rem_sh;
    logic                   rem_ge;

    assign rd_idx  = (state_reg == ST_IDLE) ? head.bucket : idx_reg;
    assign cnt_rd  = cnt_reg[rd_idx];
    assign nacc    = sat_add(acc_reg, cnt_rd);
    assign found   = (nacc > tint_reg) || ((nacc == tint_reg) && (tfrac_reg == 16'd0));
    assign is_last = (idx_reg == used);
    assign sel_c   = (head.bucket_sel > used) ? used : head.bucket_sel;
    assign sum_ext = {1'b0, sum_reg} + {{(SUM_BITS - SAMPLE_BITS + 1){1'b0}}, head.sample};
    assign tgt     = 64'(frac_reg * count_reg);
    assign rem_sh  = {rem_reg[COUNT_BITS-1:0], x_reg[PROD_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, d_reg});
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        ub = '0;
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            if (idx_reg == IDX_BITS'(i))
                ub = bounds[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_take  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    head_take = 1'b1;
                    if (head.func == FUNC_QUERY)
                        state_next = (count_reg == '0) ? ST_DONE : ST_TGT;
                    else if (head.func == FUNC_READ)
                        state_next = ST_WALK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_TGT:    state_next = ST_WALK;
            ST_WALK:
            begin
                if (func_reg == FUNC_READ)
                begin
                    if (idx_reg == sel_reg)
                        state_next = ST_DONE;
                end
                else if (found && !is_last)
                begin
                    if ((nacc == acc_reg) || (ub <= lb_reg))
                        state_next = ST_DONE;
                    else
                        state_next = ST_MUL_LO;
                end
                else if (is_last)
                    state_next = ST_DONE;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_MUL_FR;
            ST_MUL_FR: state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (dcnt_reg == DCNT_BITS'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            for (int i = 0; i < NUM_BUCKETS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (head_take && (head.func == FUNC_RECORD))
            begin
                cnt_reg[rd_idx] <= sat_add(cnt_rd, COUNT_BITS'(1));
                count_reg       <= sat_add(count_reg, COUNT_BITS'(1));
                sum_reg         <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                if (head.sample < min_reg)
                    min_reg <= head.sample;
                if (head.sample > max_reg)
                    max_reg <= head.sample;
            end
            else if (head_take && (head.func == FUNC_CLEAR))
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                for (int i = 0; i < NUM_BUCKETS; i++)
                    cnt_reg[i] <= '0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                func_reg <= head.func;
                sel_reg  <= sel_c;
                frac_reg <= (head.fraction > FRAC_ONE) ? FRAC_ONE : head.fraction;
                hit_reg  <= (head.func == FUNC_RECORD) ? head.bucket : '0;
                ans_reg  <= '0;
                acc_reg  <= '0;
                idx_reg  <= '0;
                lb_reg   <= '0;
            end
            ST_TGT:
            begin
                tint_reg  <= tgt[COUNT_BITS+15:16];
                tfrac_reg <= tgt[15:0];
            end
            ST_WALK:
            begin
                if (func_reg == FUNC_READ)
                begin
                    if (idx_reg == sel_reg)
                        ans_reg <= nacc;
                    acc_reg <= nacc;
                    idx_reg <= idx_reg + IDX_BITS'(1);
                end
                else if (found && !is_last)
                begin
                    ans_reg <= {{(COUNT_BITS - SAMPLE_BITS){1'b0}}, lb_reg};
                    d_reg   <= nacc - acc_reg;
                    a_reg   <= tint_reg - acc_reg;
                    w_reg   <= ub - lb_reg;
                end
                else if (is_last)
                    ans_reg <= {{(COUNT_BITS - SAMPLE_BITS){1'b0}}, lb_reg};
                else
                begin
                    acc_reg <= nacc;
                    lb_reg  <= ub;
                    idx_reg <= idx_reg + IDX_BITS'(1);
                end
            end
            ST_MUL_LO: x_reg <= PROD_BITS'(a_reg[HALF_BITS-1:0] * w_reg);
            ST_MUL_HI: m_reg <= PROD_BITS'(a_reg[COUNT_BITS-1:HALF_BITS] * w_reg);
            ST_MUL_FR:
            begin
                x_reg <= x_reg + (m_reg << HALF_BITS);
                m_reg <= PROD_BITS'(tfrac_reg * w_reg);
            end
            ST_SUM:
            begin
                x_reg    <= x_reg + (m_reg >> 16);
                rem_reg  <= '0;
                dcnt_reg <= DCNT_BITS'(DIV_STEPS);
            end
            ST_DIV:
            begin
                rem_reg  <= rem_ge ? (rem_sh - {1'b0, d_reg}) : rem_sh;
                x_reg    <= {x_reg[PROD_BITS-2:0], rem_ge};
                dcnt_reg <= dcnt_reg - DCNT_BITS'(1);
                if (dcnt_reg == DCNT_BITS'(1))
                    ans_reg <= {{(COUNT_BITS - SAMPLE_BITS){1'b0}}, lb_reg}
                             + {x_reg[COUNT_BITS-2:0], rem_ge};
            end
            default: ;
        endcase
        if (load_out)
        begin
            o_hit_reg   <= hit_reg;
            o_count_reg <= count_reg;
            o_sum_reg   <= sum_reg;
            o_min_reg   <= min_reg;
            o_max_reg   <= max_reg;
            o_ans_reg   <= ans_reg;
            o_empty_reg <= (count_reg == '0);
        end
    end

    assign empty       = !out_valid_reg;
    assign hit_bucket  = o_hit_reg;
    assign total_count = o_count_reg;
    assign sum_total   = o_sum_reg;
    assign min_sample  = o_min_reg;
    assign max_sample  = o_max_reg;
    assign answer      = o_ans_reg;
    assign is_empty    = o_empty_reg;

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_take |-> (state_reg == ST_IDLE))
        else $error("item taken while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, d_reg}))
        else $error("divider remainder out of range");
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("min above max");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result lost");
endmodule
`default_nettype wire

[sv/bucketed_latency_histogram.sv]
// Top level of the bucketed latency histogram: config registers and the two halves.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | func, sample, fraction, bucket_sel
//  result   | empty / pop        | hit_bucket, total_count, sum_total, min_sample,
//           |                    | max_sample, answer, is_empty
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Record and clear transactions go straight from idle to done in the back end; a cumulative
// read walks the counters (one bucket per cycle through the counter walk); a percentile
// computes its target, walks the buckets, multiplies and runs the 80-step restoring divider.
// Reset (rst_n low, async) empties both queues and restores stats and bound defaults.
// A two-entry input queue lets items enter while a result waits on the result port.
`default_nettype none
module bucketed_latency_histogram (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [1:0]                       func,
    input  wire logic [blh_pkg::SAMPLE_BITS-1:0]  sample,
    input  wire logic [blh_pkg::FRAC_BITS-1:0]    fraction,
    input  wire logic [2:0]                       bucket_sel,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [2:0]                            hit_bucket,
    output logic [blh_pkg::COUNT_BITS-1:0]        total_count,
    output logic [blh_pkg::SUM_BITS-1:0]          sum_total,
    output logic [blh_pkg::SAMPLE_BITS-1:0]       min_sample,
    output logic [blh_pkg::SAMPLE_BITS-1:0]       max_sample,
    output logic [blh_pkg::COUNT_BITS-1:0]        answer,
    output logic                                  is_empty,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [31:0]                      cfg_data
);
    import blh_pkg::*;

    logic [2:0]  biu_reg;
    bound_arr_t  bound_reg;
    logic [IDX_BITS-1:0] used;
    logic        head_valid, head_take;
    blh_item_t   head;

    // zero boundaries in use behaves as one
    assign used      = (biu_reg == 3'd0) ? IDX_BITS'(1) : biu_reg;
    assign cfg_ready = 1'b1;

    // config transaction: index 0 is the bound count, 1..7 the bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            biu_reg <= 3'(NUM_BOUNDS);
            for (int i = 0; i < NUM_BOUNDS; i++)
                bound_reg[i] <= (2 * i < SAMPLE_BITS) ? (SAMPLE_BITS'(1) << (2 * i)) : '1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BOUNDS_IN_USE)
                biu_reg <= cfg_data[2:0];
            else
            begin
                for (int i = 0; i < NUM_BOUNDS; i++)
                begin
                    if (cfg_index == 3'(i + 1))
                        bound_reg[i] <= cfg_data;
                end
            end
        end
    end

    blh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .sample     (sample),
        .fraction   (fraction),
        .bucket_sel (bucket_sel),
        .bounds     (bound_reg),
        .used       (used),
        .head_valid (head_valid),
        .head       (head),
        .head_take  (head_take)
    );

    blh_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .head_take   (head_take),
        .bounds      (bound_reg),
        .used        (used),
        .empty       (empty),
        .pop         (pop),
        .hit_bucket  (hit_bucket),
        .total_count (total_count),
        .sum_total   (sum_total),
        .min_sample  (min_sample),
        .max_sample  (max_sample),
        .answer      (answer),
        .is_empty    (is_empty)
    );
endmodule
`default_nettype wire

[tb/histogram_checker.sv]
// Checker for the bucketed latency histogram: models the block and compares every result.
`timescale 1ns / 1ps
module histogram_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic [1:0]                      func,
    input  logic [blh_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [blh_pkg::FRAC_BITS-1:0]   fraction,
    input  logic [2:0]                      bucket_sel,
    input  logic                            empty,
    input  logic                            pop,
    input  logic [2:0]                      hit_bucket,
    input  logic [blh_pkg::COUNT_BITS-1:0]  total_count,
    input  logic [blh_pkg::SUM_BITS-1:0]    sum_total,
    input  logic [blh_pkg::SAMPLE_BITS-1:0] min_sample,
    input  logic [blh_pkg::SAMPLE_BITS-1:0] max_sample,
    input  logic [blh_pkg::COUNT_BITS-1:0]  answer,
    input  logic                            is_empty,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [31:0]                     cfg_data,
    output int                              errors,
    output int                              pending
);
    import blh_pkg::*;

    typedef struct packed {
        logic [2:0]             hit;
        logic [COUNT_BITS-1:0]  total;
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] lowest;
        logic [SAMPLE_BITS-1:0] highest;
        logic [COUNT_BITS-1:0]  ans;
        logic                   none;
    } stats_t;

    stats_t                 expected_stats[$];
    logic [COUNT_BITS-1:0]  bucket_cnt [NUM_BUCKETS];
    logic [SAMPLE_BITS-1:0] edge_val [NUM_BOUNDS];
    logic [2:0]             bounds_used;
    logic [COUNT_BITS-1:0]  n_samples;
    logic [SUM_BITS-1:0]    sum_samples;
    logic [SAMPLE_BITS-1:0] lowest_seen;
    logic [SAMPLE_BITS-1:0] highest_seen;

    function automatic logic [COUNT_BITS-1:0] add_sat(input logic [COUNT_BITS-1:0] a,
                                                      input logic [COUNT_BITS-1:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function automatic int active_bounds();
        return (bounds_used == 3'd0) ? 1 : int'(bounds_used);
    endfunction

    function automatic void wipe_stats();
        foreach (bucket_cnt[i]) bucket_cnt[i] = '0;
        n_samples    = '0;
        sum_samples  = '0;
        lowest_seen  = '1;
        highest_seen = '0;
    endfunction

    // exact estimate: lower + (T - lc*2^16) * width / ((uc - lc) * 2^16), T = f * count
    function automatic logic [COUNT_BITS-1:0] estimate_percentile(input logic [FRAC_BITS-1:0] f);
        logic [127:0]           tgt;
        logic [127:0]           num;
        logic [127:0]           den;
        logic [COUNT_BITS-1:0]  acc;
        logic [COUNT_BITS-1:0]  prv;
        logic [COUNT_BITS-1:0]  lc;
        logic [COUNT_BITS-1:0]  uc;
        logic [SAMPLE_BITS-1:0] lo_edge;
        logic [SAMPLE_BITS-1:0] hi_edge;
        logic [63:0]            est;
        logic [FRAC_BITS-1:0]   fc;
        int                     used;
        int                     idx;
        bit                     found;
        used = active_bounds();
        if (n_samples == '0) return '0;
        fc = (f > FRAC_ONE) ? FRAC_ONE : f;
        tgt = 128'(fc) * 128'(n_samples);
        idx = used;
        acc = '0;
        lc = '0;
        uc = '0;
        found = 0;
        for (int i = 0; i <= used; i++) begin
            if (!found) begin
                prv = acc;
                acc = add_sat(acc, bucket_cnt[i]);
                if ((128'(acc) << 16) >= tgt) begin
                    idx = i;
                    lc = prv;
                    uc = acc;
                    found = 1;
                end
            end
        end
        lo_edge = (idx == 0) ? '0 : edge_val[idx-1];
        if (idx >= used) return COUNT_BITS'(lo_edge);
        hi_edge = edge_val[idx];
        if (uc == lc || hi_edge <= lo_edge) return COUNT_BITS'(lo_edge);
        num = (tgt - (128'(lc) << 16)) * 128'(hi_edge - lo_edge);
        den = 128'(uc - lc) << 16;
        est = 64'(lo_edge) + 64'(num / den);
        return est[COUNT_BITS-1:0];
    endfunction

    function automatic stats_t predict_stats(input logic [1:0] op,
                                             input logic [SAMPLE_BITS-1:0] smp,
                                             input logic [FRAC_BITS-1:0] fr,
                                             input logic [2:0] sel);
        stats_t           r;
        logic [SUM_BITS:0] s;
        int               used;
        int               b;
        int               upto;
        used = active_bounds();
        r = '0;
        case (op)
            FUNC_RECORD: begin
                b = used;
                for (int i = used - 1; i >= 0; i--)
                    if (smp <= edge_val[i]) b = i;
                bucket_cnt[b] = add_sat(bucket_cnt[b], COUNT_BITS'(1));
                n_samples = add_sat(n_samples, COUNT_BITS'(1));
                s = {1'b0, sum_samples} + 65'(smp);
                sum_samples = s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
                if (smp < lowest_seen) lowest_seen = smp;
                if (smp > highest_seen) highest_seen = smp;
                r.hit = 3'(b);
            end
            FUNC_QUERY: r.ans = estimate_percentile(fr);
            FUNC_CLEAR: wipe_stats();
            default: begin
                upto = (int'(sel) > used) ? used : int'(sel);
                for (int i = 0; i <= upto; i++) r.ans = add_sat(r.ans, bucket_cnt[i]);
            end
        endcase
        r.total   = n_samples;
        r.sum     = sum_samples;
        r.lowest  = lowest_seen;
        r.highest = highest_seen;
        r.none    = (n_samples == '0);
        return r;
    endfunction

    task automatic report(input string field, input logic [63:0] exp, input logic [63:0] got);
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, exp, got);
        errors++;
    endtask

    // Handshake levels are stable mid-cycle, so each transaction is taken at the falling
    // edge before the rising edge that completes it.
    always @(negedge clk or negedge rst_n) begin
        stats_t e;
        if (!rst_n) begin
            bounds_used = 3'd7;
            foreach (edge_val[i]) edge_val[i] = SAMPLE_BITS'(1) << (2 * i);
            wipe_stats();
            expected_stats.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_BOUNDS_IN_USE) bounds_used = cfg_data[2:0];
                else edge_val[cfg_index - 1] = cfg_data;
            end
            if (push && !full)
                expected_stats.insert(expected_stats.size(),
                                      predict_stats(func, sample, fraction, bucket_sel));
            if (pop && !empty) begin
                if (expected_stats.size() == 0) begin
                    report("unexpected transaction", '0, '0);
                end else begin
                    e = expected_stats.pop_front();
                    if (hit_bucket !== e.hit)
                        report("hit_bucket", 64'(e.hit), 64'(hit_bucket));
                    if (total_count !== e.total)
                        report("total_count", 64'(e.total), 64'(total_count));
                    if (sum_total !== e.sum)
                        report("sum_total", e.sum, sum_total);
                    if (min_sample !== e.lowest)
                        report("min_sample", 64'(e.lowest), 64'(min_sample));
                    if (max_sample !== e.highest)
                        report("max_sample", 64'(e.highest), 64'(max_sample));
                    if (answer !== e.ans)
                        report("answer", 64'(e.ans), 64'(answer));
                    if (is_empty !== e.none)
                        report("is_empty", 64'(e.none), 64'(is_empty));
                end
            end
        end
        pending = expected_stats.size();
    end
endmodule

[tb/testbench.sv]
// Top of the histogram testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps
module testbench;
    import blh_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASES       = 6;
    localparam int CYCLE_LIMIT  = 800000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [1:0]             func = FUNC_RECORD;
    logic [SAMPLE_BITS-1:0] sample = '0;
    logic [FRAC_BITS-1:0]   fraction = '0;
    logic [2:0]             bucket_sel = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [2:0]             hit_bucket;
    logic [COUNT_BITS-1:0]  total_count;
    logic [SUM_BITS-1:0]    sum_total;
    logic [SAMPLE_BITS-1:0] min_sample;
    logic [SAMPLE_BITS-1:0] max_sample;
    logic [COUNT_BITS-1:0]  answer;
    logic                   is_empty;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = REG_BOUNDS_IN_USE;
    logic [31:0]            cfg_data = '0;

    int                     errors;
    int                     pending;
    int                     cycles = 0;

    // stimulus-side copy of the bounds, only used to aim samples at bucket edges
    logic [SAMPLE_BITS-1:0] edge_copy [NUM_BOUNDS];
    // zero-gap mode for the sender and receiver; long receiver hold request
    bit                     no_idle = 0;
    bit                     hold_req = 0;

    always #10 clk = ~clk;

    bucketed_latency_histogram u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .sample(sample), .fraction(fraction), .bucket_sel(bucket_sel),
        .empty(empty), .pop(pop), .hit_bucket(hit_bucket), .total_count(total_count),
        .sum_total(sum_total), .min_sample(min_sample), .max_sample(max_sample),
        .answer(answer), .is_empty(is_empty), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    histogram_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func),
        .sample(sample), .fraction(fraction), .bucket_sel(bucket_sel),
        .empty(empty), .pop(pop), .hit_bucket(hit_bucket), .total_count(total_count),
        .sum_total(sum_total), .min_sample(min_sample), .max_sample(max_sample),
        .answer(answer), .is_empty(is_empty), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Watchdog: ends a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stalls before each pop, plus one long hold-off when asked.
    // pop is left high across back-to-back transactions so it never toggles within a step.
    initial begin
        int  gap;
        bit  taken;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge clk);
                taken = !empty;
                @(posedge clk);
            end while (!taken);
            // leave pop high; the next iteration decides whether to drop it
            #0;
        end
    end

    // One input transaction; push is only lowered when a gap is drawn.
    task automatic send_item(input logic [1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                             input logic [FRAC_BITS-1:0] fr, input logic [2:0] sel);
        int gap;
        bit taken;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        func       <= op;
        sample     <= smp;
        fraction   <= fr;
        bucket_sel <= sel;
        do begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx != REG_BOUNDS_IN_USE) edge_copy[idx - 1] = val;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Stop feeding and let every outstanding transaction drain before touching registers.
    task automatic drain();
        push <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    // Sample aimed at a bucket edge most of the time, fully random or extreme otherwise.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] e;
        e = edge_copy[$urandom_range(0, NUM_BOUNDS - 1)];
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return '0;
            3:       return '1;
            4:       return e + 1;
            5:       return e - 1;
            6:       return e;
            default: return e - $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FRAC_ONE;
            2:       return FRAC_BITS'($urandom_range(65537, 131071));
            default: return FRAC_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_random();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 68)
            send_item(FUNC_RECORD, pick_sample(), FRAC_BITS'($urandom), 3'($urandom));
        else if (roll < 82)
            send_item(FUNC_QUERY, $urandom, pick_fraction(), 3'($urandom));
        else if (roll < 96)
            send_item(FUNC_READ, $urandom, FRAC_BITS'($urandom), 3'($urandom_range(0, 7)));
        else
            send_item(FUNC_CLEAR, $urandom, FRAC_BITS'($urandom), 3'($urandom));
    endtask

    // Bound sets per phase: ascending with a chosen step, or scrambled.
    task automatic load_bounds(input logic [2:0] in_use, input int step, input bit scramble);
        logic [32:0] b;
        b = 33'($urandom_range(0, step));
        write_reg(REG_BOUNDS_IN_USE, 32'(in_use));
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            if (scramble) write_reg(3'(i + 1), $urandom_range(0, 5000));
            else begin
                write_reg(3'(i + 1), (b > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : b[31:0]);
                b = b + 33'($urandom_range(0, step));
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int per_phase;
        foreach (edge_copy[i]) edge_copy[i] = SAMPLE_BITS'(1) << (2 * i);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queries, edge samples at the reset bounds, clamped fractions,
        // every bucket read, clear and query after clear.
        send_item(FUNC_QUERY, '0, FRAC_ONE, '0);
        send_item(FUNC_READ, '0, '0, 3'd7);
        send_item(FUNC_RECORD, '0, '0, '0);
        send_item(FUNC_RECORD, 32'd1, '0, '0);
        send_item(FUNC_RECORD, 32'd2, '0, '0);
        send_item(FUNC_RECORD, 32'd4096, '0, '0);
        send_item(FUNC_RECORD, 32'd4097, '0, '0);
        send_item(FUNC_RECORD, '1, '0, '0);
        send_item(FUNC_QUERY, '0, '0, '0);
        send_item(FUNC_QUERY, '0, 17'd32768, '0);
        send_item(FUNC_QUERY, '0, FRAC_ONE, '0);
        send_item(FUNC_QUERY, '0, '1, '0);
        for (int s = 0; s < 8; s++) send_item(FUNC_READ, '0, '0, 3'(s));
        send_item(FUNC_CLEAR, '0, '0, '0);
        send_item(FUNC_QUERY, '0, 17'd1000, '0);
        send_item(FUNC_READ, '0, '0, 3'd3);

        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: ;  // reset bounds
                1: load_bounds(3'd1, 2000, 0);
                // extremes: bound_0 at zero, bound_6 at all ones
                2: begin
                    load_bounds(3'd7, 700000000, 0);
                    @(posedge clk);
                    write_reg(3'd1, '0);
                    write_reg(3'd7, '1);
                    cfg_valid <= 1'b0;
                end
                3: load_bounds(3'd0, 100, 0);    // zero in use acts as one
                4: load_bounds(3'($urandom_range(1, 7)), 0, 1);
                // shrink without clearing: old counters linger beyond the active set
                default: load_bounds(3'd3, 60, 0);
            endcase
            for (int k = 0; k < per_phase; k++) begin
                if (p == 2 && k == 20) begin
                    // receiver stops for a long stretch while records keep coming
                    hold_req = 1;
                    no_idle = 1;
                    for (int j = 0; j < 12; j++) send_item(FUNC_RECORD, pick_sample(), '0, '0);
                    no_idle = 0;
                end
                no_idle = (k % 60) >= 45;  // back-to-back stretches each phase
                send_random();
            end
            no_idle = 0;
        end

        drain();
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
